// ===== hdl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// shared types and constants of the flowspec nlri parser
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int MaxComponents = 16;

  localparam logic [3:0] PH_LEN0   = 4'd0;
  localparam logic [3:0] PH_LEN1   = 4'd1;
  localparam logic [3:0] PH_TYPE   = 4'd2;
  localparam logic [3:0] PH_PLEN   = 4'd3;
  localparam logic [3:0] PH_PBYTES = 4'd4;
  localparam logic [3:0] PH_OP     = 4'd5;
  localparam logic [3:0] PH_VAL    = 4'd6;
  localparam logic [3:0] PH_SKIP   = 4'd7;

  localparam logic [2:0] KIND_TERM   = 3'd0;
  localparam logic [2:0] KIND_PHDR   = 3'd1;
  localparam logic [2:0] KIND_PBYTE  = 3'd2;
  localparam logic [2:0] KIND_EEND   = 3'd3;
  localparam logic [2:0] KIND_PERR   = 3'd4;
  localparam logic [2:0] KIND_TRUNC  = 3'd5;

  localparam logic [7:0] LONG_LEN = 8'd240;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  component_type;
    logic        term_end;
    logic        and_flag;
    logic        less;
    logic        greater;
    logic        equal;
    logic [63:0] term_value;
    logic [7:0]  prefix_length;
    logic [5:0]  component_index;
    logic [15:0] entry_index;
    logic        last;
  } out_word_t;

  // front to back: up to two results caused by one byte
  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } pair_t;

endpackage

// ===== hdl/fsp_front.sv =====
// ----------------------------------------------------------------------------
// fsp_front
// byte parser: takes one byte a cycle while take is high and builds its zero, one or two results
// ----------------------------------------------------------------------------
module fsp_front import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     family_is_v6,
  input  in_word_t in_word,
  input  logic     take,
  output logic     has_res,
  output pair_t    res
);

  logic [3:0]  phase, phase_next;
  logic [3:0]  len_hi, len_hi_next;
  logic [11:0] ebl, ebl_next;
  logic [7:0]  ctype, ctype_next;
  logic [7:0]  cop, cop_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  vbl, vbl_next;
  logic [4:0]  pbl, pbl_next;
  logic [6:0]  ccount, ccount_next;
  logic [15:0] ecount, ecount_next;

  logic [7:0]  b;
  logic [11:0] ebl_dec;
  logic [5:0]  nb;
  logic [3:0]  vb;
  logic [11:0] newlen;
  logic        n_one, n_two;
  out_word_t   r0, r1, rtmp;

  function automatic out_word_t mk(input logic [2:0] k, input logic [7:0] t,
                                   input logic [6:0] cc, input logic [15:0] ec);
    out_word_t w;
    w = '0;
    w.kind = k;
    w.component_type = t;
    w.component_index = cc[5:0];
    w.entry_index = ec;
    return w;
  endfunction

  always_comb begin
    phase_next = phase; len_hi_next = len_hi; ebl_next = ebl;
    ctype_next = ctype; cop_next = cop; acc_next = acc; vbl_next = vbl;
    pbl_next = pbl; ccount_next = ccount; ecount_next = ecount;
    b = in_word.byte_value;
    ebl_dec = ebl - 12'd1;
    nb = 6'((9'(b) + 9'd7) >> 3);
    vb = 4'd1 << b[5:4];
    newlen = (phase == PH_LEN1) ? {len_hi, b} : {4'd0, b};
    n_one = 1'b0; n_two = 1'b0;
    r0 = '0; r1 = '0; rtmp = '0;
    if (phase == PH_LEN0 && b >= LONG_LEN) begin
      len_hi_next = b[3:0];
      phase_next = PH_LEN1;
    end else if (phase == PH_LEN0 || phase == PH_LEN1) begin
      ebl_next = newlen;
      ccount_next = '0;
      if (newlen == '0) begin
        r0 = mk(KIND_EEND, '0, '0, ecount);
        n_one = 1'b1;
        ecount_next = ecount + 16'd1;
        phase_next = PH_LEN0;
      end else begin
        phase_next = PH_TYPE;
      end
    end else if (phase >= PH_TYPE && phase <= PH_SKIP && ebl != '0) begin
      ebl_next = ebl_dec;
      case (phase)
        PH_TYPE: begin
          if (ccount >= 7'(MaxComponents)) phase_next = PH_SKIP;
          else begin
            ctype_next = b;
            phase_next = (b == 8'd1 || b == 8'd2) ? PH_PLEN : PH_OP;
          end
        end
        PH_PLEN: begin
          rtmp = mk(KIND_PHDR, ctype, ccount, ecount);
          rtmp.prefix_length = b;
          n_one = 1'b1;
          if (b > (family_is_v6 ? 8'd128 : 8'd32) || 12'(nb) > ebl_dec) begin
            rtmp.kind = KIND_PERR;
            phase_next = PH_SKIP;
          end else if (nb == '0) begin
            ccount_next = ccount + 7'd1;
            phase_next = PH_TYPE;
          end else begin
            pbl_next = nb[4:0];
            phase_next = PH_PBYTES;
          end
          r0 = rtmp;
        end
        PH_PBYTES: begin
          rtmp = mk(KIND_PBYTE, ctype, ccount, ecount);
          rtmp.term_value = {56'd0, b};
          r0 = rtmp;
          n_one = 1'b1;
          pbl_next = pbl - 5'd1;
          if (pbl == 5'd1) begin
            ccount_next = ccount + 7'd1;
            phase_next = PH_TYPE;
          end
        end
        PH_OP: begin
          cop_next = b;
          if (12'(vb) > ebl_dec) phase_next = PH_SKIP;
          else begin
            vbl_next = vb;
            acc_next = '0;
            phase_next = PH_VAL;
          end
        end
        PH_VAL: begin
          acc_next = {acc[55:0], b};
          vbl_next = vbl - 4'd1;
          if (vbl == 4'd1) begin
            rtmp = mk(KIND_TERM, ctype, ccount, ecount);
            rtmp.term_end = cop[7];
            rtmp.and_flag = cop[6];
            rtmp.less = cop[3];
            rtmp.greater = cop[2];
            rtmp.equal = cop[1];
            rtmp.term_value = {acc[55:0], b};
            r0 = rtmp;
            n_one = 1'b1;
            if (cop[7]) begin
              ccount_next = ccount + 7'd1;
              phase_next = PH_TYPE;
            end else phase_next = PH_OP;
          end
        end
        default: ;
      endcase
      if (ebl_dec == '0) begin
        rtmp = mk(KIND_EEND, '0, ccount_next, ecount);
        if (n_one) begin r1 = rtmp; n_two = 1'b1; end
        else begin r0 = rtmp; n_one = 1'b1; end
        ecount_next = ecount + 16'd1;
        phase_next = PH_LEN0;
      end
    end else begin
      phase_next = PH_LEN0;
    end
    if (in_word.buffer_last) begin
      if (phase_next != PH_LEN0) begin
        rtmp = mk(KIND_TRUNC, '0, ccount_next, ecount_next);
        if (n_one) begin r1 = rtmp; n_two = 1'b1; end
        else begin r0 = rtmp; n_one = 1'b1; end
      end
      phase_next = PH_LEN0; ebl_next = '0; vbl_next = '0; pbl_next = '0;
      ccount_next = '0; ecount_next = '0;
    end
    if (n_two) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  assign has_res = n_one;
  assign res.two = n_two;
  assign res.first = r0;
  assign res.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN0; len_hi <= '0; ebl <= '0; ctype <= '0; cop <= '0;
      acc <= '0; vbl <= '0; pbl <= '0; ccount <= '0; ecount <= '0;
    end else if (take) begin
      phase <= phase_next; len_hi <= len_hi_next; ebl <= ebl_next;
      ctype <= ctype_next; cop <= cop_next; acc <= acc_next; vbl <= vbl_next;
      pbl <= pbl_next; ccount <= ccount_next; ecount <= ecount_next;
    end
  end

endmodule

// ===== hdl/fsp_back.sv =====
// ----------------------------------------------------------------------------
// fsp_back
// two-entry queue of result pairs; while out_ready is high, hands out one result word a cycle
// ----------------------------------------------------------------------------
module fsp_back import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pair_t     push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  pair_t      slot [2];
  logic       wptr, rptr, half;
  logic [1:0] count;
  logic       pop_word, pop_pair;

  assign can_push  = (count != 2'd2) || pop_pair;
  assign out_valid = (count != 2'd0);
  assign out_word  = half ? slot[rptr].second : slot[rptr].first;
  assign pop_word  = out_valid && out_ready;
  assign pop_pair  = pop_word && (half || !slot[rptr].two);

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; half <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop_pair) begin
        rptr <= ~rptr;
        half <= 1'b0;
      end else if (pop_word) half <= 1'b1;
      count <= count + 2'(push) - 2'(pop_pair);
    end
  end

endmodule

// ===== hdl/flowspec_nlri_parser_top.sv =====
// ----------------------------------------------------------------------------
// flowspec_nlri_parser_top
// flowspec nlri byte-stream parser: one byte in, zero to two result words out
// ----------------------------------------------------------------------------
//  channel  signals                          word
//  in       in_valid / in_ready / in_data    in_word_t (byte_value, buffer_last)
//  out      out_valid / out_ready / out_data out_word_t (kind ... last)
//  cfg      cfg_we / cfg_data                family_is_v6
//
// one byte accepted per cycle while in_ready is high; the parser state updates in that cycle
// a byte making two results hands out its first word and then its second
// a two-pair queue between parser and output lets the parser run while
// the output stalls; in_ready drops only when that queue is full
// rst is synchronous, active high, and returns to waiting for an entry length
module flowspec_nlri_parser_top import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic  family_is_v6;
  logic  take;
  logic  has_res;
  logic  can_push;
  pair_t res;

  // address family register
  always_ff @(posedge clk) begin
    if (rst) family_is_v6 <= 1'b0;
    else if (cfg_we) family_is_v6 <= cfg_data;
  end

  // accept a byte whenever the queue has room for its results
  assign in_ready = can_push;
  assign take     = in_valid && in_ready;

  fsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .family_is_v6 (family_is_v6),
    .in_word      (in_data),
    .take         (take),
    .has_res      (has_res),
    .res          (res)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (take && has_res),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_data)
  );

endmodule

// ===== hdl/fsp_checker.sv =====
// ----------------------------------------------------------------------------
// fsp_checker
// port-level checks of the parser top level
// ----------------------------------------------------------------------------
module fsp_checker import fsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output word changed while stalled");

  // kind stays within the defined codes
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kind <= KIND_TRUNC)
    else $error("bad kind");

  // entry end and truncation carry no component type
  a_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_EEND || out_data.kind == KIND_TRUNC)
      |-> out_data.component_type == 8'd0)
    else $error("type on entry end");

  // truncation is always the last word of its byte
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_TRUNC |-> out_data.last)
    else $error("truncation not last");

  // an empty queue never holds off the input
  a_room: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty queue");

endmodule

bind flowspec_nlri_parser_top fsp_checker u_fsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
